// ===== rtl/evfq_pkg.sv =====
// types and codes shared by the event queue files
package evfq_pkg;

	localparam logic KIND_PUSH  = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_DROPPED = 2'd1,
		ST_INVALID = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_DRAIN
	} fsm_t;

	typedef struct packed {
		logic               kind;
		logic [6:0]         max_count;
		logic [63:0]        in_timestamp;
		logic signed [63:0] in_value;
		logic [31:0]        in_name_id;
		logic [31:0]        in_thread_id;
		logic [31:0]        in_correlation;
		logic [15:0]        in_type;
		logic [15:0]        in_flags;
	} cmd_t;

	typedef struct packed {
		status_t            status;
		logic               last;
		logic [63:0]        out_timestamp;
		logic signed [63:0] out_value;
		logic [31:0]        out_name_id;
		logic [31:0]        out_thread_id;
		logic [31:0]        out_correlation;
		logic [15:0]        out_type;
		logic [15:0]        out_flags;
		logic [8:0]         pending;
		logic [31:0]        accepted_count;
		logic [31:0]        dropped_count;
	} res_t;

	// one stored event, 256 bits
	typedef struct packed {
		logic [63:0] timestamp;
		logic [63:0] value;
		logic [31:0] name_id;
		logic [31:0] tid;
		logic [31:0] correlation;
		logic [15:0] ev_type;
		logic [15:0] flags;
	} ev_t;

	localparam int EV_W = $bits(ev_t);

endpackage

// ===== rtl/evfq_ram.sv =====
// event store: one write port, one read port, registered read data
module evfq_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/event_fifo_drop_on_full_unit.sv =====
// top level of the bounded profiling event queue
//
// Commands enter on cmd and are taken when start is high and busy is low.
// A push (kind 0) stores one event unless its type is zero (status invalid)
// or the ring already holds DEPTH events (status dropped, drop counter
// advances). A drain (kind 1) returns up to max_count events, saturated to
// MAX_DRAIN, oldest first, the final one marked by last; an empty ring or a
// zero count gives one result with status empty.
// Every result appears on result for one cycle with strobe high, registered
// from the transfer or store read that caused it, and carries the pending
// count and the accepted and dropped totals. The receiver cannot stall the block.
// Pushes may follow each other every cycle while busy is low. A drain reads
// its events one after another through the store's single read port; busy
// stays high after taking a drain of more than one event, until its last read.
// Reset clears the pointers, fill level and both totals; the store itself
// is not cleared, as no slot is read before it has been written.
module event_fifo_drop_on_full_unit #(
	parameter int DEPTH     = 256,
	parameter int MAX_DRAIN = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  evfq_pkg::cmd_t cmd,
	output logic           busy,
	output logic           strobe,
	output evfq_pkg::res_t result
);

	import evfq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam int CW = (FW > 7) ? FW : 7;

	fsm_t           state_q, state_d;
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [FW-1:0]  fill_q;
	logic [31:0]    acc_q, drop_q;
	logic [6:0]     left_q, left_d;

	logic           vld_s1;
	status_t        status_s1;
	logic           last_s1;
	logic           has_ev_s1;

	logic           accept, is_push, type_ok, full;
	logic           wr_en, drop_inc, rd_en, rd_last, empty_drain;
	logic [6:0]     want, n_take;
	ev_t            wr_ev, rd_ev;
	logic [EV_W-1:0] rd_data;

	assign busy    = (state_q == S_DRAIN);
	assign accept  = start && !busy;
	assign is_push = (cmd.kind == KIND_PUSH);
	assign type_ok = (cmd.in_type != 16'd0);
	assign full    = (fill_q == FW'(DEPTH));

	assign wr_en    = accept && is_push && type_ok && !full;
	assign drop_inc = accept && is_push && type_ok && full;

	// drain size: saturate, then limit to what the ring holds
	assign want   = (cmd.max_count > 7'(MAX_DRAIN)) ? 7'(MAX_DRAIN) : cmd.max_count;
	assign n_take = (CW'(want) < CW'(fill_q)) ? want : 7'(fill_q);
	assign empty_drain = accept && !is_push && (n_take == 7'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		left_d  = left_q;
		rd_en   = 1'b0;
		rd_last = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && !is_push && n_take != 7'd0) begin
					rd_en   = 1'b1;
					rd_last = (n_take == 7'd1);
					left_d  = n_take - 7'd1;
					if (n_take != 7'd1) begin
						state_d = S_DRAIN;
					end
				end
			end
			S_DRAIN: begin
				rd_en   = 1'b1;
				rd_last = (left_q == 7'd1);
				left_d  = left_q - 7'd1;
				if (left_q == 7'd1) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			acc_q    <= '0;
			drop_q   <= '0;
			left_q   <= '0;
			vld_s1   <= 1'b0;
		end else begin
			left_q <= left_d;
			vld_s1 <= (accept && is_push) || empty_drain || rd_en;
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
				fill_q   <= fill_q + 1'b1;
				acc_q    <= acc_q + 32'd1;
			end else if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
				fill_q   <= fill_q - 1'b1;
			end
			if (drop_inc) begin
				drop_q <= drop_q + 32'd1;
			end
		end
	end

	// result tags travel alongside the store read
	always_ff @(posedge clk) begin
		has_ev_s1 <= rd_en;
		if (rd_en) begin
			status_s1 <= ST_OK;
			last_s1   <= rd_last;
		end else if (empty_drain) begin
			status_s1 <= ST_EMPTY;
			last_s1   <= 1'b1;
		end else begin
			last_s1 <= 1'b1;
			if (!type_ok) begin
				status_s1 <= ST_INVALID;
			end else if (full) begin
				status_s1 <= ST_DROPPED;
			end else begin
				status_s1 <= ST_OK;
			end
		end
	end

	always_comb begin
		wr_ev.timestamp   = cmd.in_timestamp;
		wr_ev.value       = cmd.in_value;
		wr_ev.name_id     = cmd.in_name_id;
		wr_ev.tid         = cmd.in_thread_id;
		wr_ev.correlation = cmd.in_correlation;
		wr_ev.ev_type     = cmd.in_type;
		wr_ev.flags       = cmd.in_flags;
	end

	evfq_ram #(
		.DEPTH (DEPTH),
		.WIDTH (EV_W)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_ptr_q),
		.wdata (wr_ev),
		.re    (rd_en),
		.raddr (rd_ptr_q),
		.rdata (rd_data)
	);

	// event fields read as zero on results that carry no event
	assign rd_ev = has_ev_s1 ? ev_t'(rd_data) : '0;

	// totals and fill level already stand at their after-transfer values
	assign strobe = vld_s1;
	always_comb begin
		result.status          = status_s1;
		result.last            = last_s1;
		result.out_timestamp   = rd_ev.timestamp;
		result.out_value       = rd_ev.value;
		result.out_name_id     = rd_ev.name_id;
		result.out_thread_id   = rd_ev.tid;
		result.out_correlation = rd_ev.correlation;
		result.out_type        = rd_ev.ev_type;
		result.out_flags       = rd_ev.flags;
		result.pending         = 9'(fill_q);
		result.accepted_count  = acc_q;
		result.dropped_count   = drop_q;
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the profiling event queue with drop on full
module testbench;
	import evfq_pkg::*;

	localparam int RING_SLOTS = 256;
	localparam int DRAIN_CAP  = 64;

	typedef struct packed {
		logic [63:0] timestamp;
		logic [63:0] value;
		logic [31:0] name_id;
		logic [31:0] tid;
		logic [31:0] correlation;
		logic [15:0] ev_kind;
		logic [15:0] flags;
	} trace_rec_t;

	typedef struct {
		cmd_t    op;
		bit      pinned;
		status_t st;
		int      pend;
		int      acc;
		int      drop;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic start;
	cmd_t cmd;
	logic busy;
	logic strobe;
	res_t result;

	// typed-in result for the directed rows, travels with the command
	logic pin_valid;
	res_t pin_res;

	// shadow of the queue
	trace_rec_t  shadow_ring [RING_SLOTS];
	logic [7:0]  shadow_wr;
	logic [7:0]  shadow_rd;
	logic [8:0]  shadow_fill;
	logic [31:0] shadow_accepted;
	logic [31:0] shadow_dropped;

	res_t awaited_results [$];
	int   mismatches;
	bit   no_idle;

	event_fifo_drop_on_full_unit dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.busy  (busy),
		.strobe(strobe),
		.result(result)
	);

	always #5 clk = ~clk;

	function automatic cmd_t mk_push(logic [63:0] ts, logic [63:0] val, logic [31:0] nm,
			logic [31:0] th, logic [31:0] co, logic [15:0] ty, logic [15:0] fl);
		cmd_t c;
		c = '0;
		c.kind           = KIND_PUSH;
		c.in_timestamp   = ts;
		c.in_value       = val;
		c.in_name_id     = nm;
		c.in_thread_id   = th;
		c.in_correlation = co;
		c.in_type        = ty;
		c.in_flags       = fl;
		return c;
	endfunction

	function automatic cmd_t mk_drain(int n);
		cmd_t c;
		c = '0;
		c.kind      = KIND_DRAIN;
		c.max_count = n[6:0];
		return c;
	endfunction

	function automatic cmd_t rand_push(bit allow_invalid);
		cmd_t c;
		c = mk_push({$urandom, $urandom}, {$urandom, $urandom}, $urandom, $urandom, $urandom,
			16'($urandom_range(1, 65535)), 16'($urandom));
		c.max_count = 7'($urandom);
		if (allow_invalid && $urandom_range(0, 9) == 0)
			c.in_type = '0;
		return c;
	endfunction

	// drain with noise in the ignored payload fields
	function automatic cmd_t rand_drain();
		cmd_t c;
		int   r;
		c      = rand_push(1'b1);
		c.kind = KIND_DRAIN;
		r      = $urandom_range(0, 99);
		if (r < 70)
			c.max_count = 7'($urandom_range(0, 8));
		else if (r < 90)
			c.max_count = 7'($urandom_range(9, DRAIN_CAP));
		else
			c.max_count = 7'($urandom_range(DRAIN_CAP + 1, 127));
		return c;
	endfunction

	function automatic res_t pinned(status_t st, int pend, int acc, int drop);
		res_t r;
		r                = '0;
		r.status         = st;
		r.last           = 1'b1;
		r.pending        = pend[8:0];
		r.accepted_count = acc;
		r.dropped_count  = drop;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// works out the results of one accepted command and updates the shadow
	function automatic void predict_queue_op(cmd_t c);
		res_t       r;
		trace_rec_t e;
		int         want;
		int         n;
		r = '0;
		if (c.kind == KIND_PUSH) begin
			r.last = 1'b1;
			if (c.in_type == '0) begin
				r.status = ST_INVALID;
			end else if (shadow_fill == 9'(RING_SLOTS)) begin
				shadow_dropped = shadow_dropped + 1;
				r.status       = ST_DROPPED;
			end else begin
				shadow_ring[shadow_wr] = '{c.in_timestamp, c.in_value, c.in_name_id,
					c.in_thread_id, c.in_correlation, c.in_type, c.in_flags};
				shadow_wr       = 8'(shadow_wr + 1);
				shadow_fill     = 9'(shadow_fill + 1);
				shadow_accepted = shadow_accepted + 1;
				r.status        = ST_OK;
			end
			r.pending        = shadow_fill;
			r.accepted_count = shadow_accepted;
			r.dropped_count  = shadow_dropped;
			awaited_results.push_back(r);
			return;
		end
		want = (c.max_count > DRAIN_CAP) ? DRAIN_CAP : int'(c.max_count);
		n    = (want < int'(shadow_fill)) ? want : int'(shadow_fill);
		if (n == 0) begin
			r.status         = ST_EMPTY;
			r.last           = 1'b1;
			r.pending        = shadow_fill;
			r.accepted_count = shadow_accepted;
			r.dropped_count  = shadow_dropped;
			awaited_results.push_back(r);
			return;
		end
		for (int k = 0; k < n; k++) begin
			e           = shadow_ring[shadow_rd];
			shadow_rd   = 8'(shadow_rd + 1);
			shadow_fill = 9'(shadow_fill - 1);
			r.status          = ST_OK;
			r.last            = (k == n - 1);
			r.out_timestamp   = e.timestamp;
			r.out_value       = e.value;
			r.out_name_id     = e.name_id;
			r.out_thread_id   = e.tid;
			r.out_correlation = e.correlation;
			r.out_type        = e.ev_kind;
			r.out_flags       = e.flags;
			r.pending         = shadow_fill;
			r.accepted_count  = shadow_accepted;
			r.dropped_count   = shadow_dropped;
			awaited_results.push_back(r);
		end
	endfunction

	function automatic void check_field(string fname, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$error("%s: expected %0h, actual %0h", fname, want, got);
		end
	endfunction

	function automatic void check_result(res_t got);
		res_t want;
		if (awaited_results.size() == 0) begin
			mismatches++;
			$error("result with none awaited: status %0d", got.status);
			return;
		end
		want = awaited_results.pop_front();
		check_field("status", 64'(want.status), 64'(got.status));
		check_field("last", 64'(want.last), 64'(got.last));
		check_field("out_timestamp", want.out_timestamp, got.out_timestamp);
		check_field("out_value", want.out_value, got.out_value);
		check_field("out_name_id", 64'(want.out_name_id), 64'(got.out_name_id));
		check_field("out_thread_id", 64'(want.out_thread_id), 64'(got.out_thread_id));
		check_field("out_correlation", 64'(want.out_correlation),
			64'(got.out_correlation));
		check_field("out_type", 64'(want.out_type), 64'(got.out_type));
		check_field("out_flags", 64'(want.out_flags), 64'(got.out_flags));
		check_field("pending", 64'(want.pending), 64'(got.pending));
		check_field("accepted_count", 64'(want.accepted_count), 64'(got.accepted_count));
		check_field("dropped_count", 64'(want.dropped_count), 64'(got.dropped_count));
	endfunction

	// results are taken before commands so a transfer never sees its own results
	always @(posedge clk) begin
		if (arst_n && strobe)
			check_result(result);
		if (arst_n && start && !busy) begin
			predict_queue_op(cmd);
			if (pin_valid)
				awaited_results[$] = pin_res;
		end
	end

	task automatic issue(cmd_t c, bit pin, res_t pres);
		int gap;
		cmd       <= c;
		start     <= 1'b1;
		pin_valid <= pin;
		pin_res   <= pres;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		dir_row_t rows [12];
		int       to_fill;
		clk             = 1'b0;
		arst_n          = 1'b0;
		start           = 1'b0;
		cmd             = '0;
		pin_valid       = 1'b0;
		pin_res         = '0;
		shadow_wr       = '0;
		shadow_rd       = '0;
		shadow_fill     = '0;
		shadow_accepted = '0;
		shadow_dropped  = '0;
		mismatches      = 0;
		no_idle         = 1'b0;

		rows = '{
			'{mk_drain(5), 1'b1, ST_EMPTY, 0, 0, 0},
			'{mk_push('1, '1, '1, '1, '1, 16'h0000, '1), 1'b1, ST_INVALID, 0, 0, 0},
			'{mk_push('1, '1, '1, '1, '1, 16'hffff, 16'hffff), 1'b1, ST_OK, 1, 1, 0},
			'{mk_push('0, '0, '0, '0, '0, 16'h0001, 16'h0000), 1'b1, ST_OK, 2, 2, 0},
			'{mk_push(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 32'haaaa_aaaa,
				32'haaaa_aaaa, 32'haaaa_aaaa, 16'h5555, 16'haaaa), 1'b1, ST_OK, 3, 3, 0},
			'{mk_push(64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff, 32'h5555_5555,
				32'h5555_5555, 32'h5555_5555, 16'haaaa, 16'h5555), 1'b1, ST_OK, 4, 4, 0},
			'{mk_drain(0), 1'b1, ST_EMPTY, 4, 4, 0},
			'{mk_drain(1), 1'b0, ST_OK, 0, 0, 0},
			'{mk_drain(127), 1'b0, ST_OK, 0, 0, 0},
			'{mk_drain(64), 1'b1, ST_EMPTY, 0, 4, 0},
			'{mk_push('0, '0, '0, '0, '0, 16'h0000, 16'h0000), 1'b1, ST_INVALID, 0, 4, 0},
			'{mk_push(64'h1, 64'hffff_ffff_ffff_fffe, 32'h1, 32'h2, 32'h3, 16'h8000,
				16'h0001), 1'b0, ST_OK, 0, 0, 0}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (rows[i])
			issue(rows[i].op, rows[i].pinned,
				pinned(rows[i].st, rows[i].pend, rows[i].acc, rows[i].drop));

		// hold off until the queue has answered everything
		settle();

		// fill to the brim, then push into a full ring: drops, and an invalid type
		to_fill = RING_SLOTS - int'(shadow_fill);
		for (int i = 0; i < to_fill; i++) begin
			if (i == 40)
				no_idle = 1'b1;
			if (i == 140)
				no_idle = 1'b0;
			issue(rand_push(1'b0), 1'b0, '0);
		end
		for (int i = 0; i < 4; i++)
			issue(rand_push(1'b0), 1'b0, '0);
		issue(mk_push('1, '1, '1, '1, '1, 16'h0000, '1), 1'b0, '0);
		issue(rand_push(1'b0), 1'b0, '0);
		// empty the ring so the read pointer wraps as well
		issue(mk_drain(DRAIN_CAP), 1'b0, '0);
		issue(mk_drain(127), 1'b0, '0);
		issue(mk_drain(DRAIN_CAP), 1'b0, '0);
		issue(mk_drain(DRAIN_CAP), 1'b0, '0);

		for (int i = 0; i < 10; i++) begin
			if (i % 40 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < 60)
				issue(rand_push(1'b1), 1'b0, '0);
			else
				issue(rand_drain(), 1'b0, '0);
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== event_fifo_drop_on_full_unit.f =====
rtl/evfq_pkg.sv
rtl/evfq_ram.sv
rtl/event_fifo_drop_on_full_unit.sv
tb/sv/testbench.sv
